[hdl/fch_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Folded character histogram package
// Shared sizes, character constants, request codes and a bitmap helper.
// ----------------------------------------------------------------------------
package fch_pkg;

  localparam int ALPHABET_SIZE = 128;
  localparam int SYM_BITS      = 7;
  localparam int TOTAL_BITS    = 24;
  localparam int REPORT_BITS   = 16;
  localparam int COUNT_BITS_DEF = 16;

  localparam logic [7:0] CHAR_SPACE   = 8'd32;
  localparam logic [7:0] CHAR_LOWER_A = 8'd97;
  localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  typedef enum logic [0:0] {
    OP_COUNT = 1'b0,
    OP_READ  = 1'b1
  } opcode_t;

  typedef logic [ALPHABET_SIZE-1:0] bitmap_t;
  typedef logic [SYM_BITS-1:0]      sym_t;

  function automatic sym_t lowest_set(input bitmap_t v);
    sym_t idx;
    idx = '0;
    for (int i = ALPHABET_SIZE - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = sym_t'(i);
      end
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

[hdl/folded_char_histogram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Folded character histogram
// Counts bytes 33..127 with a-z folded to upper case and reads back the
// nonzero counts in ascending symbol order, wrapping after the highest one.
//
// Input channel (item_valid / item_stall) carries opcode and char_code.
// A count request (OP_COUNT) produces no result; bytes at or below space and
// bytes 128..255 are dropped. For a countable byte the count memory is read
// in the accept cycle and the incremented value is written back in the
// next, so item_stall is high for one cycle after the transfer.
// A read request (OP_READ) picks the next nonzero symbol from the cursor
// with a priority encoder over a 128-bit occupancy bitmap, reads its count
// and loads the result register in state S_RD once the result channel is
// free; item_stall stays high until then.
// The result channel (result_valid / result_stall) is one output register;
// while it is stalled a pending read result waits and item_stall stays high.
// Reset clears the occupancy bitmap, total and cursor; an entry whose
// bitmap bit is clear reads as zero, so the memory needs no clearing.
// ----------------------------------------------------------------------------
module folded_char_histogram #(
  parameter int COUNT_BITS = fch_pkg::COUNT_BITS_DEF
) (
  input  wire  logic                             clk,
  input  wire  logic                             rst,
  input  wire  logic                             item_valid,
  output       logic                             item_stall,
  input  wire  logic                             opcode,
  input  wire  logic [7:0]                       char_code,
  output       logic                             result_valid,
  input  wire  logic                             result_stall,
  output       logic [fch_pkg::SYM_BITS-1:0]     symbol,
  output       logic [fch_pkg::REPORT_BITS-1:0]  symbol_count,
  output       logic [fch_pkg::TOTAL_BITS-1:0]   grand_total,
  output       logic                             empty_res,
  output       logic                             last
);
  import fch_pkg::*;

  localparam int EXT_W = (COUNT_BITS > REPORT_BITS) ? COUNT_BITS : REPORT_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INC,
    S_RD
  } state_t;

  state_t                  state;
  bitmap_t                 bitmap;
  sym_t                    cursor;
  sym_t                    addr;
  sym_t                    addr_next;
  logic [TOTAL_BITS-1:0]   total;
  logic                    pend_empty;
  logic                    pend_last;

  logic [COUNT_BITS-1:0]   mem [ALPHABET_SIZE];
  logic [COUNT_BITS-1:0]   mem_q;
  logic [COUNT_BITS-1:0]   rd_count;
  logic [COUNT_BITS-1:0]   cnt_inc;
  logic [EXT_W-1:0]        cnt_ext;
  logic [REPORT_BITS-1:0]  cnt_report;

  logic       item_take;
  logic       result_free;
  logic       countable;
  logic [7:0] code_folded;
  bitmap_t    from_cursor;
  bitmap_t    above_pick;
  sym_t       pick;
  logic       pick_last;

  always_comb begin
    item_stall  = (state != S_IDLE);
    item_take   = item_valid && !item_stall;
    result_free = !result_valid || !result_stall;

    countable   = !char_code[7] && (char_code > CHAR_SPACE);
    code_folded = (char_code >= CHAR_LOWER_A && char_code <= CHAR_LOWER_Z) ?
                  (char_code - CASE_OFFSET) : char_code;

    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      from_cursor[i] = bitmap[i] && (sym_t'(i) >= cursor);
    end
    pick = (|from_cursor) ? lowest_set(from_cursor) : lowest_set(bitmap);
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      above_pick[i] = bitmap[i] && (sym_t'(i) > pick);
    end
    pick_last = !(|above_pick);

    addr_next = addr;
    if (state == S_IDLE && item_take) begin
      addr_next = (opcode_t'(opcode) == OP_COUNT) ? code_folded[SYM_BITS-1:0] : pick;
    end

    rd_count   = bitmap[addr] ? mem_q : '0;
    cnt_inc    = (rd_count == '1) ? rd_count : rd_count + COUNT_BITS'(1);
    cnt_ext    = EXT_W'(rd_count);
    cnt_report = (cnt_ext > EXT_W'({REPORT_BITS{1'b1}})) ?
                 {REPORT_BITS{1'b1}} : cnt_ext[REPORT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (state == S_INC) begin
      mem[addr] <= cnt_inc;
    end
    mem_q <= mem[addr_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      bitmap       <= '0;
      cursor       <= '0;
      total        <= '0;
    end else begin
      if (result_valid && !result_stall && state != S_RD) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_take) begin
            addr <= addr_next;
            if (opcode_t'(opcode) == OP_COUNT) begin
              if (countable) begin
                if (total != '1) begin
                  total <= total + TOTAL_BITS'(1);
                end
                state <= S_INC;
              end
            end else begin
              pend_empty <= (total == '0);
              pend_last  <= pick_last;
              if (total != '0) begin
                cursor <= pick_last ? '0 : pick + sym_t'(1);
              end
              state <= S_RD;
            end
          end
        end
        S_INC: begin
          bitmap[addr] <= 1'b1;
          state        <= S_IDLE;
        end
        S_RD: begin
          if (result_free) begin
            result_valid <= 1'b1;
            empty_res    <= pend_empty;
            symbol       <= pend_empty ? '0 : addr;
            symbol_count <= pend_empty ? '0 : cnt_report;
            grand_total  <= total;
            last         <= pend_empty ? 1'b0 : pend_last;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_result_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_RD)
    else $error("result loaded outside read state");

  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && empty_res |-> symbol == '0 && symbol_count == '0 && last == 1'b0)
    else $error("empty result carries data");

  a_nonempty_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && !empty_res |-> symbol_count != '0)
    else $error("reported symbol has zero count");

  a_total_bitmap: assert property (@(posedge clk) disable iff (rst)
    total == '0 |-> bitmap == '0)
    else $error("occupied entry with zero total");
`endif

endmodule
`default_nettype wire

[bench/folded_char_histogram_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Folded character histogram testbench
// Drives count and read requests through the valid/stall input channel and
// checks each readout against a local model of the count table, the total
// and the scan cursor, or pinned rows against typed values. It runs a short
// table of boundary cases, then random traffic with bursts of idling on both
// sides, a long result stall, a drain pause and a final no-idle stretch.
// ----------------------------------------------------------------------------
module folded_char_histogram_test;
  import fch_pkg::*;

  typedef struct packed {
    sym_t                   symbol;
    logic [REPORT_BITS-1:0] tally;
    logic [TOTAL_BITS-1:0]  total;
    logic                   empty;
    logic                   last;
  } readout_t;

  typedef struct packed {
    opcode_t    op;
    logic [7:0] code;
    logic       pinned;
    readout_t   want;
  } stim_row_t;

  localparam readout_t NO_COUNTS = '{symbol: '0, tally: '0, total: '0, empty: 1'b1, last: 1'b0};
  localparam readout_t FIRST_BANG = '{symbol: 7'd33, tally: 16'd1, total: 24'd7, empty: 1'b0,
                                      last: 1'b0};
  localparam readout_t TOP_DEL = '{symbol: 7'd127, tally: 16'd1, total: 24'd7, empty: 1'b0,
                                   last: 1'b1};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic opcode = OP_COUNT;
  logic [7:0] char_code = 8'd0;
  logic result_valid;
  logic result_stall = 1'b0;
  sym_t symbol;
  logic [REPORT_BITS-1:0] symbol_count;
  logic [TOTAL_BITS-1:0] grand_total;
  logic empty_res;
  logic last;

  // tags a transfer whose readout is typed into the table
  logic pin_use = 1'b0;
  readout_t pin_val = NO_COUNTS;

  logic [REPORT_BITS-1:0] tally [ALPHABET_SIZE];
  logic [TOTAL_BITS-1:0] tally_total;
  sym_t scan_from;
  readout_t readout_q [$];
  int mismatches = 0;
  logic idle_on = 1'b1;
  int hold_cycles = 0;

  folded_char_histogram u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .opcode       (opcode),
    .char_code    (char_code),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .symbol       (symbol),
    .symbol_count (symbol_count),
    .grand_total  (grand_total),
    .empty_res    (empty_res),
    .last         (last)
  );

  always #1 clk = ~clk;

  function automatic void tally_byte(input logic [7:0] code);
    sym_t s;
    if (code <= CHAR_SPACE || code[7]) return;
    s = sym_t'((code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) ? code - CASE_OFFSET : code);
    if (tally[s] != '1) tally[s] = tally[s] + 1'b1;
    if (tally_total != '1) tally_total = tally_total + 1'b1;
  endfunction

  function automatic readout_t next_readout();
    readout_t r;
    sym_t k;
    logic hit;
    r = NO_COUNTS;
    hit = 1'b0;
    if (tally_total == '0) return r;
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      k = scan_from + sym_t'(i);
      if (!hit && tally[k] != '0) begin
        hit = 1'b1;
        r.symbol = k;
      end
    end
    if (!hit) return r;
    r.empty = 1'b0;
    r.tally = tally[r.symbol];
    r.total = tally_total;
    r.last = 1'b1;
    for (int i = int'(r.symbol) + 1; i < ALPHABET_SIZE; i++) begin
      if (tally[i] != '0) r.last = 1'b0;
    end
    scan_from = r.last ? sym_t'(0) : r.symbol + 1'b1;
    return r;
  endfunction

  // track accepted requests
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ALPHABET_SIZE; i++) tally[i] = '0;
      tally_total = '0;
      scan_from = '0;
    end else if (item_valid && !item_stall) begin
      if (opcode == OP_READ) begin
        if (pin_use) begin
          void'(next_readout());
          readout_q.push_back(pin_val);
        end else begin
          readout_q.push_back(next_readout());
        end
      end else begin
        tally_byte(char_code);
      end
    end
  end

  always @(posedge clk) begin
    readout_t got;
    readout_t want;
    if (!rst && result_valid && !result_stall) begin
      got = '{symbol, symbol_count, grand_total, empty_res, last};
      if (readout_q.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected readout sym=%0d n=%0d tot=%0d empty=%b last=%b", $time,
                   got.symbol, got.tally, got.total, got.empty, got.last);
        mismatches++;
      end else begin
        want = readout_q.pop_front();
        if (got.symbol !== want.symbol || got.tally !== want.tally ||
            got.total !== want.total || got.empty !== want.empty || got.last !== want.last) begin
          if (mismatches < 10)
            $display("%0t: want %0d/%0d/%0d/%b/%b got %0d/%0d/%0d/%b/%b",
                     $time, want.symbol, want.tally, want.total, want.empty, want.last,
                     got.symbol, got.tally, got.total, got.empty, got.last);
          mismatches++;
        end
      end
    end
  end

  // result side: random stall bursts, or one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        result_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        result_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        result_stall <= 1'b0;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  task automatic push_item(input opcode_t op, input logic [7:0] code, input logic pinned,
                           input readout_t want);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    item_valid <= 1'b1;
    opcode <= op;
    char_code <= code;
    pin_use <= pinned;
    pin_val <= want;
    do @(posedge clk); while (item_stall);
  endtask

  initial begin
    stim_row_t plan [21];
    int counted;
    int read_pct;
    logic held;
    logic drained;
    opcode_t op;
    logic [7:0] code;
    plan = '{
      '{OP_READ,  8'd0,   1'b1, NO_COUNTS},
      '{OP_COUNT, 8'd0,   1'b0, NO_COUNTS},
      '{OP_COUNT, 8'd10,  1'b0, NO_COUNTS},
      '{OP_COUNT, 8'd32,  1'b0, NO_COUNTS},
      '{OP_COUNT, 8'd128, 1'b0, NO_COUNTS},
      '{OP_COUNT, 8'd255, 1'b0, NO_COUNTS},
      '{OP_READ,  8'd255, 1'b1, NO_COUNTS},
      '{OP_COUNT, 8'd33,  1'b0, NO_COUNTS},
      '{OP_COUNT, 8'd127, 1'b0, NO_COUNTS},
      '{OP_COUNT, 8'd97,  1'b0, NO_COUNTS},
      '{OP_COUNT, 8'd122, 1'b0, NO_COUNTS},
      '{OP_COUNT, 8'd65,  1'b0, NO_COUNTS},
      '{OP_COUNT, 8'd96,  1'b0, NO_COUNTS},
      '{OP_COUNT, 8'd123, 1'b0, NO_COUNTS},
      '{OP_READ,  8'd0,   1'b1, FIRST_BANG},
      '{OP_READ,  8'd0,   1'b0, NO_COUNTS},
      '{OP_READ,  8'd0,   1'b0, NO_COUNTS},
      '{OP_READ,  8'd0,   1'b0, NO_COUNTS},
      '{OP_READ,  8'd0,   1'b0, NO_COUNTS},
      '{OP_READ,  8'd0,   1'b1, TOP_DEL},
      '{OP_READ,  8'd0,   1'b1, FIRST_BANG}
    };
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) push_item(plan[i].op, plan[i].code, plan[i].pinned, plan[i].want);

    counted = 0;
    read_pct = 25;
    held = 1'b0;
    drained = 1'b0;
    for (int draws = 0; counted < 1100; draws++) begin
      if (draws % 150 == 0) begin
        idle_on = $urandom_range(0, 3) != 0;
        read_pct = $urandom_range(0, 2) == 0 ? 60 : $urandom_range(5, 30);
      end
      if (!held && counted >= 500) begin
        // hold results while requests keep coming
        held = 1'b1;
        hold_cycles = $urandom_range(150, 300);
        repeat (3) push_item(OP_READ, 8'($urandom_range(0, 255)), 1'b0, NO_COUNTS);
      end
      if (!drained && counted >= 1000) begin
        drained = 1'b1;
        item_valid <= 1'b0;
        do @(posedge clk); while (readout_q.size() != 0);
      end
      op = $urandom_range(1, 100) <= read_pct ? OP_READ : OP_COUNT;
      code = $urandom_range(0, 4) == 0 ? 8'($urandom_range(0, 255)) : 8'($urandom_range(33, 127));
      if (op == OP_READ || (code > CHAR_SPACE && !code[7])) counted++;
      push_item(op, code, 1'b0, NO_COUNTS);
    end

    // finish without idling
    idle_on = 1'b0;
    repeat (150) begin
      op = $urandom_range(1, 100) <= 30 ? OP_READ : OP_COUNT;
      code = 8'($urandom_range(0, 255));
      push_item(op, code, 1'b0, NO_COUNTS);
    end

    item_valid <= 1'b0;
    do @(posedge clk); while (readout_q.size() != 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && readout_q.size() == 0) begin
      $display("folded_char_histogram_test passed");
    end else begin
      $display("folded_char_histogram_test failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("folded_char_histogram_test failed");
    $finish;
  end

endmodule
